FILE: rtl/mwma_pkg.sv
`default_nettype none

package mwma_pkg;

	localparam int unsigned LONG_WINDOW_DEF = 960;
	localparam int unsigned VALUE_BITS_DEF  = 48;
	localparam int unsigned IN_W            = 48;
	localparam int unsigned OUT_W           = 48;
	// four window means, so the final divide is a shift
	localparam int unsigned MEAN_SHIFT      = 2;
	// index of the last register stage of the divide pipelines
	localparam int unsigned DIV_STAGES      = 3;

	typedef struct packed {
		logic en;
		logic out_load;
	} pipe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mwma_delay_seg.sv
`default_nettype none

module mwma_delay_seg #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned W     = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	generate
		if (DEPTH == 1) begin : g_reg
			logic [W-1:0] data_q;

			always_ff @(posedge clk) begin
				if (shift) begin
					data_q <= din;
				end
			end

			assign dout = data_q;
		end else begin : g_mem
			localparam int unsigned PW = $clog2(DEPTH);
			localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

			logic [W-1:0]  mem [DEPTH];
			logic [PW-1:0] ptr_q;
			logic [PW-1:0] ptr_nxt;
			logic [W-1:0]  rd_q;

			always_comb begin
				ptr_nxt = ptr_q;
				if (shift) begin
					if (ptr_q == LAST) begin
						ptr_nxt = '0;
					end else begin
						ptr_nxt = ptr_q + PW'(1);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_nxt;
				end
			end

			// read ahead at the slot the next transaction will overwrite
			always_ff @(posedge clk) begin
				if (shift) begin
					mem[ptr_q] <= din;
				end
				rd_q <= mem[ptr_nxt];
			end

			assign dout = rd_q;
		end
	endgenerate

endmodule

`default_nettype wire

FILE: rtl/mwma_window.sv
`default_nettype none

module mwma_window
	import mwma_pkg::*;
#(
	parameter  int unsigned LONG_WINDOW = LONG_WINDOW_DEF,
	parameter  int unsigned VALUE_BITS  = VALUE_BITS_DEF,
	localparam int unsigned WH   = LONG_WINDOW / 2,
	localparam int unsigned WQ   = LONG_WINDOW / 4,
	localparam int unsigned WE   = LONG_WINDOW / 8,
	localparam int unsigned SL_W = VALUE_BITS + $clog2(LONG_WINDOW),
	localparam int unsigned SH_W = VALUE_BITS + $clog2(WH),
	localparam int unsigned SQ_W = VALUE_BITS + $clog2(WQ),
	localparam int unsigned SE_W = VALUE_BITS + $clog2(WE)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic      [SL_W-1:0]       sum_long_nxt,
	output logic      [SH_W-1:0]       sum_half_nxt,
	output logic      [SQ_W-1:0]       sum_quarter_nxt,
	output logic      [SE_W-1:0]       sum_eighth_nxt,
	output logic                       full_nxt
);

	localparam int unsigned FW = $clog2(LONG_WINDOW + 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(LONG_WINDOW);

	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         fill_nxt;
	logic [VALUE_BITS-1:0] raw_e, raw_q, raw_h, raw_l;
	logic [VALUE_BITS-1:0] old_e, old_q, old_h, old_l;
	logic [SL_W-1:0]       sum_long_q;
	logic [SH_W-1:0]       sum_half_q;
	logic [SQ_W-1:0]       sum_quarter_q;
	logic [SE_W-1:0]       sum_eighth_q;

	// chained delay line, tapped at each window length
	mwma_delay_seg #(.DEPTH(WE), .W(VALUE_BITS)) u_seg_e (
		.clk(clk), .arst_n(arst_n), .shift(accept), .din(value), .dout(raw_e)
	);
	mwma_delay_seg #(.DEPTH(WQ - WE), .W(VALUE_BITS)) u_seg_q (
		.clk(clk), .arst_n(arst_n), .shift(accept), .din(old_e), .dout(raw_q)
	);
	mwma_delay_seg #(.DEPTH(WH - WQ), .W(VALUE_BITS)) u_seg_h (
		.clk(clk), .arst_n(arst_n), .shift(accept), .din(old_q), .dout(raw_h)
	);
	mwma_delay_seg #(.DEPTH(LONG_WINDOW - WH), .W(VALUE_BITS)) u_seg_l (
		.clk(clk), .arst_n(arst_n), .shift(accept), .din(old_h), .dout(raw_l)
	);

	// entries never written read as zero
	assign old_e = (fill_q >= FW'(WE)) ? raw_e : '0;
	assign old_q = (fill_q >= FW'(WQ)) ? raw_q : '0;
	assign old_h = (fill_q >= FW'(WH)) ? raw_h : '0;
	assign old_l = (fill_q >= FILL_MAX) ? raw_l : '0;

	assign fill_nxt = (accept && (fill_q != FILL_MAX)) ? fill_q + FW'(1) : fill_q;
	assign full_nxt = (fill_nxt == FILL_MAX);

	always_comb begin
		sum_long_nxt    = sum_long_q;
		sum_half_nxt    = sum_half_q;
		sum_quarter_nxt = sum_quarter_q;
		sum_eighth_nxt  = sum_eighth_q;
		if (accept) begin
			sum_long_nxt    = sum_long_q + SL_W'(value) - SL_W'(old_l);
			sum_half_nxt    = sum_half_q + SH_W'(value) - SH_W'(old_h);
			sum_quarter_nxt = sum_quarter_q + SQ_W'(value) - SQ_W'(old_q);
			sum_eighth_nxt  = sum_eighth_q + SE_W'(value) - SE_W'(old_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			sum_long_q    <= '0;
			sum_half_q    <= '0;
			sum_quarter_q <= '0;
			sum_eighth_q  <= '0;
		end else begin
			fill_q        <= fill_nxt;
			sum_long_q    <= sum_long_nxt;
			sum_half_q    <= sum_half_nxt;
			sum_quarter_q <= sum_quarter_nxt;
			sum_eighth_q  <= sum_eighth_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mwma_div_lane.sv
`default_nettype none

module mwma_div_lane #(
	parameter int unsigned DIVISOR = 960,
	parameter int unsigned DIV_W   = 58,
	parameter int unsigned QW      = 48
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [DIV_W-1:0] dividend,
	output logic      [QW-1:0]    quotient
);

	function automatic int unsigned low_zeros(input int unsigned d);
		int unsigned n;
		n = 0;
		while ((n < 31) && (((d >> n) & 32'd1) == 32'd0)) begin
			n++;
		end
		return n;
	endfunction

	function automatic logic [127:0] recip(input int unsigned sh, input int unsigned d);
		logic [127:0] p;
		p = 128'd1 << sh;
		return (p + 128'(d) - 128'd1) / 128'(d);
	endfunction

	localparam int unsigned CH  = 32;
	localparam int unsigned TZ  = low_zeros(DIVISOR);
	localparam int unsigned ODD = DIVISOR >> TZ;
	localparam int unsigned XW  = DIV_W - TZ;
	localparam int unsigned SH  = XW + $clog2(ODD);
	localparam int unsigned MW  = XW + 1;
	localparam int unsigned NX  = (XW + CH - 1) / CH;
	localparam int unsigned NM  = (MW + CH - 1) / CH;
	localparam int unsigned XP  = NX * CH;
	localparam int unsigned MP  = NM * CH;
	localparam int unsigned RW  = MP + CH;
	localparam int unsigned PW  = XP + MP;
	localparam logic [127:0]  RECIP_WIDE = recip(SH, ODD);
	localparam logic [MP-1:0] RECIP      = RECIP_WIDE[MP-1:0];

	// power of two as a shift, odd part by reciprocal multiply in 32-bit pieces
	logic [XP-1:0]   x_s1;
	logic [2*CH-1:0] pp_s2  [NX][NM];
	logic [RW-1:0]   row_d  [NX];
	logic [RW-1:0]   row_s3 [NX];
	logic [PW-1:0]   total;
	logic [QW-1:0]   quot_s4;

	always_comb begin
		for (int unsigned i = 0; i < NX; i++) begin
			row_d[i] = '0;
			for (int unsigned j = 0; j < NM; j++) begin
				row_d[i] = row_d[i] + (RW'(pp_s2[i][j]) << (CH * j));
			end
		end
		total = '0;
		for (int unsigned i = 0; i < NX; i++) begin
			total = total + (PW'(row_s3[i]) << (CH * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= XP'(dividend[DIV_W-1:TZ]);
			for (int unsigned i = 0; i < NX; i++) begin
				for (int unsigned j = 0; j < NM; j++) begin
					pp_s2[i][j] <= (2*CH)'(x_s1[i*CH +: CH]) * (2*CH)'(RECIP[j*CH +: CH]);
				end
			end
			row_s3  <= row_d;
			quot_s4 <= total[SH +: QW];
		end
	end

	assign quotient = quot_s4;

endmodule

`default_nettype wire

FILE: rtl/mwma_ctrl.sv
`default_nettype none

module mwma_ctrl
	import mwma_pkg::*;
#(
	parameter int unsigned STAGES = DIV_STAGES
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire logic      result_ready,
	input  wire logic      full_nxt,
	output logic           item_ready,
	output logic           result_valid,
	output logic           history_full,
	output pipe_ctl_t      ctl
);

	logic [STAGES:0] v_q;
	logic [STAGES:0] full_s;
	logic            out_valid_q;
	logic            out_full_q;
	logic            adv_out;
	logic            en;

	// pipeline moves unless the tail stage holds a transaction that cannot leave
	assign adv_out = !out_valid_q || result_ready;
	assign en      = adv_out || !v_q[STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (en) begin
				v_q <= {v_q[STAGES-1:0], item_valid};
			end
			if (adv_out) begin
				out_valid_q <= v_q[STAGES];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s <= {full_s[STAGES-1:0], full_nxt};
		end
		if (adv_out) begin
			out_full_q <= full_s[STAGES];
		end
	end

	assign item_ready   = en;
	assign result_valid = out_valid_q;
	assign history_full = out_full_q;
	assign ctl.en       = en;
	assign ctl.out_load = adv_out;

endmodule

`default_nettype wire

FILE: rtl/multi_window_moving_average_unit.sv
// channel   handshake                   payload                         moves when
// input     item_valid / item_ready     block_value                     valid & ready
// output    result_valid / result_ready ribbon_average, history_full    valid & ready
//
// one transaction per cycle unless a waiting result holds the pipeline;
// sums and divide operands, partial products, row sums and quotients take one stage each
// reset clears pointers, fill count, running sums and valid bits; history memory
// is not cleared, the fill count masks slots not yet written, so no clearing pass
// a waiting result blocks input only once a transaction reaches the quotient stage;
// then the whole pipeline holds, so up to five transactions fit before the input stalls
`default_nettype none

module multi_window_moving_average_unit
	import mwma_pkg::*;
#(
	parameter int unsigned LONG_WINDOW = LONG_WINDOW_DEF,
	parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic [IN_W-1:0]  block_value,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output logic      [OUT_W-1:0] ribbon_average,
	output logic                  history_full
);

	localparam int unsigned WH    = LONG_WINDOW / 2;
	localparam int unsigned WQ    = LONG_WINDOW / 4;
	localparam int unsigned WE    = LONG_WINDOW / 8;
	localparam int unsigned SL_W  = VALUE_BITS + $clog2(LONG_WINDOW);
	localparam int unsigned SH_W  = VALUE_BITS + $clog2(WH);
	localparam int unsigned SQ_W  = VALUE_BITS + $clog2(WQ);
	localparam int unsigned SE_W  = VALUE_BITS + $clog2(WE);
	localparam int unsigned MS_W  = VALUE_BITS + MEAN_SHIFT;

	pipe_ctl_t             ctl;
	logic                  accept;
	logic [VALUE_BITS-1:0] value;
	logic [SL_W-1:0]       sum_long_nxt;
	logic [SH_W-1:0]       sum_half_nxt;
	logic [SQ_W-1:0]       sum_quarter_nxt;
	logic [SE_W-1:0]       sum_eighth_nxt;
	logic                  full_nxt;
	logic [VALUE_BITS-1:0] mean_l, mean_h, mean_q, mean_e;
	logic [MS_W-1:0]       mean_sum;
	logic [OUT_W-1:0]      ribbon_q;

	assign accept = item_valid && item_ready;
	assign value  = VALUE_BITS'(block_value);

	mwma_window #(
		.LONG_WINDOW(LONG_WINDOW),
		.VALUE_BITS (VALUE_BITS)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.value          (value),
		.sum_long_nxt   (sum_long_nxt),
		.sum_half_nxt   (sum_half_nxt),
		.sum_quarter_nxt(sum_quarter_nxt),
		.sum_eighth_nxt (sum_eighth_nxt),
		.full_nxt       (full_nxt)
	);

	mwma_div_lane #(.DIVISOR(LONG_WINDOW), .DIV_W(SL_W), .QW(VALUE_BITS)) u_div_l (
		.clk(clk), .en(ctl.en), .dividend(sum_long_nxt), .quotient(mean_l)
	);
	mwma_div_lane #(.DIVISOR(WH), .DIV_W(SH_W), .QW(VALUE_BITS)) u_div_h (
		.clk(clk), .en(ctl.en), .dividend(sum_half_nxt), .quotient(mean_h)
	);
	mwma_div_lane #(.DIVISOR(WQ), .DIV_W(SQ_W), .QW(VALUE_BITS)) u_div_q (
		.clk(clk), .en(ctl.en), .dividend(sum_quarter_nxt), .quotient(mean_q)
	);
	mwma_div_lane #(.DIVISOR(WE), .DIV_W(SE_W), .QW(VALUE_BITS)) u_div_e (
		.clk(clk), .en(ctl.en), .dividend(sum_eighth_nxt), .quotient(mean_e)
	);

	mwma_ctrl #(.STAGES(DIV_STAGES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.result_ready(result_ready),
		.full_nxt    (full_nxt),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.history_full(history_full),
		.ctl         (ctl)
	);

	assign mean_sum = MS_W'(mean_l) + MS_W'(mean_h) + MS_W'(mean_q) + MS_W'(mean_e);

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			ribbon_q <= OUT_W'(mean_sum[MS_W-1:MEAN_SHIFT]);
		end
	end

	assign ribbon_average = ribbon_q;

`ifndef NO_ASSERTIONS
	a_sums_nested: assert property (@(posedge clk) disable iff (!arst_n)
		(SL_W'(sum_eighth_nxt) <= SL_W'(sum_quarter_nxt)) &&
		(SL_W'(sum_quarter_nxt) <= SL_W'(sum_half_nxt)) &&
		(SL_W'(sum_half_nxt) <= sum_long_nxt))
		else $error("shorter window sum exceeds a longer one");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_nxt |=> full_nxt)
		else $error("history full flag dropped");

	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input held without a stalled result");
`endif

endmodule

`default_nettype wire
